// ===== design/ts_cc_pkg.sv =====
package ts_cc_pkg;

  // Header layout
  localparam int unsigned PID_W   = 13;
  localparam int unsigned CC_W    = 4;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned TALLY_W = 32;

  localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h47;

  // Default table depth: one entry per packet id
  localparam int unsigned ID_COUNT_DEF = 8192;

  // Fixed-point reciprocal for the id-to-entry reduction
  localparam int unsigned RECIP_SHIFT = 26;

  typedef enum logic {
    FUNC_CHECK      = 1'b0,
    FUNC_READ_CLEAR = 1'b1
  } func_t;

  // One table entry: seen mark and the next expected counter
  typedef struct packed {
    logic            seen;
    logic [CC_W-1:0] cc;
  } entry_t;

endpackage

// ===== design/ts_cc_if.sv =====
interface ts_cc_in_if
  import ts_cc_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              func;
  logic [BYTE_W-1:0] hdr_byte0;
  logic [BYTE_W-1:0] hdr_byte1;
  logic [BYTE_W-1:0] hdr_byte2;
  logic [BYTE_W-1:0] hdr_byte3;

  modport source (
    output valid, func, hdr_byte0, hdr_byte1, hdr_byte2, hdr_byte3,
    input  ready
  );
  modport sink (
    input  valid, func, hdr_byte0, hdr_byte1, hdr_byte2, hdr_byte3,
    output ready
  );
endinterface

interface ts_cc_out_if
  import ts_cc_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               sync_ok;
  logic               gap_flag;
  logic [TALLY_W-1:0] error_total;

  modport source (
    output valid, sync_ok, gap_flag, error_total,
    input  ready
  );
  modport sink (
    input  valid, sync_ok, gap_flag, error_total,
    output ready
  );
endinterface

// ===== design/ts_cc_table.sv =====
module ts_cc_table
  import ts_cc_pkg::*;
#(
  parameter int unsigned ID_COUNT = ID_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rd_en,
  input  logic [$clog2(ID_COUNT)-1:0] rd_addr,
  output entry_t                      rd_entry,
  input  logic                        wr_en,
  input  logic [$clog2(ID_COUNT)-1:0] wr_addr,
  input  entry_t                      wr_entry,
  output logic                        busy
);

  localparam int unsigned IDX_W = $clog2(ID_COUNT);

  entry_t mem [ID_COUNT];

  logic             busy_r;
  logic [IDX_W-1:0] clr_addr_r;

  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  entry_t           mem_wd;

  // Clearing sweep owns the write port after reset
  always_comb begin
    if (busy_r) begin
      mem_we = 1'b1;
      mem_wa = clr_addr_r;
      mem_wd = '0;
    end else begin
      mem_we = wr_en;
      mem_wa = wr_addr;
      mem_wd = wr_entry;
    end
  end

  // Advance the sweep one entry per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b1;
      clr_addr_r <= '0;
    end else if (busy_r) begin
      clr_addr_r <= IDX_W'(clr_addr_r + 1'b1);
      if (clr_addr_r == IDX_W'(ID_COUNT - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Single-port write, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_entry <= mem[rd_addr];
    end
  end

  assign busy = busy_r;

endmodule

// ===== design/ts_continuity_checker.sv =====
// Channel  Dir  Handshake      Payload
// in_ch    in   valid/ready    func, hdr_byte0..hdr_byte3
// out_ch   out  valid/ready    sync_ok, gap_flag, error_total
//
// One item per cycle sustained while out_ch.ready is high; every item yields
// one result item, staged by id reduction, entry reduction, table read, output.
// The rate is set by the single read-modify-write of the counter table per
// item; a write to the entry being read in the same cycle is forwarded.
// After reset the table is swept to unseen, with in_ch.ready low until it ends.
// A stalled output holds itself and stage 3; empty stages 1-2 still fill behind.
module ts_continuity_checker
  import ts_cc_pkg::*;
#(
  parameter int unsigned ID_COUNT = ID_COUNT_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  ts_cc_in_if.sink     in_ch,
  ts_cc_out_if.source  out_ch
);

  localparam int unsigned IDX_W = $clog2(ID_COUNT);
  localparam int unsigned NW    = $clog2(ID_COUNT + 1);
  localparam int unsigned PROD_W = PID_W + RECIP_SHIFT;
  localparam logic [RECIP_SHIFT-1:0] RECIP_MUL =
    RECIP_SHIFT'((64'd1 << RECIP_SHIFT) / ID_COUNT);

  // Stage enables, bubbles in stages 1 and 2 collapse
  logic en1, en2, en3;
  logic busy;

  // Stage 1: quotient estimate
  logic             s1_v_r;
  func_t            s1_func_r;
  logic             s1_chk_r;
  logic [PID_W-1:0] s1_pid_r;
  logic [PID_W-1:0] s1_q_r;
  logic [CC_W-1:0]  s1_cc_r;

  // Stage 2: table index
  logic             s2_v_r;
  func_t            s2_func_r;
  logic             s2_chk_r;
  logic [IDX_W-1:0] s2_idx_r;
  logic [CC_W-1:0]  s2_cc_r;

  // Stage 3: read-modify-write
  logic             s3_v_r;
  func_t            s3_func_r;
  logic             s3_chk_r;
  logic [IDX_W-1:0] s3_idx_r;
  logic [CC_W-1:0]  s3_cc_r;
  logic             s3_fwd_r;
  entry_t           s3_fwd_ent_r;

  logic               tally_en;
  logic [TALLY_W-1:0] error_tally_r, error_tally_nxt;

  logic               out_valid_r;
  logic               out_sync_r;
  logic               out_gap_r;
  logic [TALLY_W-1:0] out_total_r;

  logic [PID_W-1:0]  in_pid;
  logic [PROD_W-1:0] in_prod;
  logic [PID_W+NW-1:0] qn_full;
  logic [PID_W-1:0]  rem;
  logic [IDX_W-1:0]  idx_nxt;

  entry_t rd_entry;
  entry_t cur_ent;
  entry_t new_ent;
  logic   gap;
  logic   wr_en;
  logic   fwd_nxt;
  logic [TALLY_W-1:0] total_nxt;

  assign en3 = !out_valid_r || out_ch.ready;
  assign en2 = !s2_v_r || en3;
  assign en1 = !s1_v_r || en2;
  assign in_ch.ready = en1 && !busy;

  // Quotient estimate: pid * floor(2^S / N) >> S, low by at most one
  assign in_pid  = {in_ch.hdr_byte1[PID_W-BYTE_W-1:0], in_ch.hdr_byte2};
  assign in_prod = PROD_W'(in_pid) * PROD_W'(RECIP_MUL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en1) begin
      s1_v_r <= in_ch.valid && in_ch.ready;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_func_r <= func_t'(in_ch.func);
      s1_chk_r  <= (func_t'(in_ch.func) == FUNC_CHECK) && (in_ch.hdr_byte0 == SYNC_BYTE);
      s1_pid_r  <= in_pid;
      s1_q_r    <= in_prod[PROD_W-1:RECIP_SHIFT];
      s1_cc_r   <= in_ch.hdr_byte3[CC_W-1:0];
    end
  end

  // Remainder, then one conditional subtract
  assign qn_full = (PID_W + NW)'(s1_q_r) * (PID_W + NW)'(ID_COUNT);
  assign rem     = PID_W'(s1_pid_r - qn_full[PID_W-1:0]);

  always_comb begin
    if ((PID_W + 1)'(rem) >= (PID_W + 1)'(ID_COUNT)) begin
      idx_nxt = IDX_W'(rem - PID_W'(ID_COUNT));
    end else begin
      idx_nxt = IDX_W'(rem);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en2) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_func_r <= s1_func_r;
      s2_chk_r  <= s1_chk_r;
      s2_idx_r  <= idx_nxt;
      s2_cc_r   <= s1_cc_r;
    end
  end

  // Forward the entry written in the cycle it is read
  assign fwd_nxt = wr_en && (s3_idx_r == s2_idx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en3) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_func_r    <= s2_func_r;
      s3_chk_r     <= s2_chk_r;
      s3_idx_r     <= s2_idx_r;
      s3_cc_r      <= s2_cc_r;
      s3_fwd_r     <= fwd_nxt;
      s3_fwd_ent_r <= new_ent;
    end
  end

  // Compare against the expected counter and form the write-back
  assign cur_ent     = s3_fwd_r ? s3_fwd_ent_r : rd_entry;
  assign gap         = s3_chk_r && cur_ent.seen && (cur_ent.cc != s3_cc_r);
  assign new_ent.seen = 1'b1;
  assign new_ent.cc   = CC_W'(s3_cc_r + 1'b1);
  assign wr_en       = s3_v_r && en3 && s3_chk_r;
  assign tally_en    = s3_v_r && en3;

  // Update the error tally in item order
  always_comb begin
    error_tally_nxt = error_tally_r;
    total_nxt       = error_tally_r;
    unique case (s3_func_r)
      FUNC_READ_CLEAR: begin
        error_tally_nxt = '0;
      end
      FUNC_CHECK: begin
        if (gap) begin
          error_tally_nxt = TALLY_W'(error_tally_r + 1'b1);
        end
        total_nxt = error_tally_nxt;
      end
      default: begin
        error_tally_nxt = error_tally_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_tally_r <= '0;
    end else if (tally_en) begin
      error_tally_r <= error_tally_nxt;
    end
  end

  // Output register: hold while the sink stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en3) begin
      out_valid_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      out_sync_r  <= s3_chk_r;
      out_gap_r   <= gap;
      out_total_r <= total_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.sync_ok     = out_sync_r;
  assign out_ch.gap_flag    = out_gap_r;
  assign out_ch.error_total = out_total_r;

  ts_cc_table #(
    .ID_COUNT (ID_COUNT)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (en3),
    .rd_addr  (s2_idx_r),
    .rd_entry (rd_entry),
    .wr_en    (wr_en),
    .wr_addr  (s3_idx_r),
    .wr_entry (new_ent),
    .busy     (busy)
  );

endmodule
